// ===== rtl/core/llr_pkg.sv =====
// ----------------------------------------------------------------------------
// llr_pkg
// Shared types and the fixed rule table of the loop automaton.
// ----------------------------------------------------------------------------
package llr_pkg;

	localparam int StateW = 3;

	typedef logic [StateW-1:0] state_t;

	typedef struct packed {
		state_t center_state;
		state_t up_state;
		state_t right_state;
		state_t down_state;
		state_t left_state;
	} cell_in_t;

	typedef struct packed {
		state_t next_state;
		logic   rule_matched;
	} cell_out_t;

	// lookup result: hit flag and new state
	typedef struct packed {
		logic   hit;
		state_t next;
	} rule_hit_t;

	// key is five octal digits: centre, then four neighbours clockwise
	function automatic rule_hit_t rule_lookup(input logic [14:0] key);
		rule_hit_t r;
		r = '{hit: 1'b1, next: 3'd0};
		case (key)
			15'o00000: r.next = 3'd0; 15'o00001: r.next = 3'd2; 15'o00002: r.next = 3'd0;
			15'o00003: r.next = 3'd0; 15'o00005: r.next = 3'd0; 15'o00006: r.next = 3'd3;
			15'o00007: r.next = 3'd1; 15'o00011: r.next = 3'd2; 15'o00012: r.next = 3'd2;
			15'o00013: r.next = 3'd2; 15'o00021: r.next = 3'd2; 15'o00022: r.next = 3'd0;
			15'o00023: r.next = 3'd0; 15'o00026: r.next = 3'd2; 15'o00027: r.next = 3'd2;
			15'o00032: r.next = 3'd0; 15'o00052: r.next = 3'd5; 15'o00062: r.next = 3'd2;
			15'o00072: r.next = 3'd2; 15'o00102: r.next = 3'd2; 15'o00112: r.next = 3'd0;
			15'o00202: r.next = 3'd0; 15'o00203: r.next = 3'd0; 15'o00205: r.next = 3'd0;
			15'o00212: r.next = 3'd5; 15'o00222: r.next = 3'd0; 15'o00232: r.next = 3'd2;
			15'o00522: r.next = 3'd2; 15'o01232: r.next = 3'd1; 15'o01242: r.next = 3'd1;
			15'o01252: r.next = 3'd5; 15'o01262: r.next = 3'd1; 15'o01272: r.next = 3'd1;
			15'o01275: r.next = 3'd1; 15'o01422: r.next = 3'd1; 15'o01432: r.next = 3'd1;
			15'o01442: r.next = 3'd1; 15'o01472: r.next = 3'd1; 15'o01625: r.next = 3'd1;
			15'o01722: r.next = 3'd1; 15'o01725: r.next = 3'd5; 15'o01752: r.next = 3'd1;
			15'o01762: r.next = 3'd1; 15'o01772: r.next = 3'd1; 15'o02527: r.next = 3'd1;
			15'o10001: r.next = 3'd1; 15'o10006: r.next = 3'd1; 15'o10007: r.next = 3'd7;
			15'o10011: r.next = 3'd1; 15'o10012: r.next = 3'd1; 15'o10021: r.next = 3'd1;
			15'o10024: r.next = 3'd4; 15'o10027: r.next = 3'd7; 15'o10051: r.next = 3'd1;
			15'o10101: r.next = 3'd1; 15'o10111: r.next = 3'd1; 15'o10124: r.next = 3'd4;
			15'o10127: r.next = 3'd7; 15'o10202: r.next = 3'd6; 15'o10212: r.next = 3'd1;
			15'o10221: r.next = 3'd1; 15'o10224: r.next = 3'd4; 15'o10226: r.next = 3'd3;
			15'o10227: r.next = 3'd7; 15'o10232: r.next = 3'd7; 15'o10242: r.next = 3'd4;
			15'o10262: r.next = 3'd6; 15'o10264: r.next = 3'd4; 15'o10267: r.next = 3'd7;
			15'o10271: r.next = 3'd0; 15'o10272: r.next = 3'd7; 15'o10542: r.next = 3'd7;
			15'o11112: r.next = 3'd1; 15'o11122: r.next = 3'd1; 15'o11124: r.next = 3'd4;
			15'o11125: r.next = 3'd1; 15'o11126: r.next = 3'd1; 15'o11127: r.next = 3'd7;
			15'o11152: r.next = 3'd2; 15'o11212: r.next = 3'd1; 15'o11222: r.next = 3'd1;
			15'o11224: r.next = 3'd4; 15'o11225: r.next = 3'd1; 15'o11227: r.next = 3'd7;
			15'o11232: r.next = 3'd1; 15'o11242: r.next = 3'd4; 15'o11262: r.next = 3'd1;
			15'o11272: r.next = 3'd7; 15'o11322: r.next = 3'd1; 15'o12224: r.next = 3'd4;
			15'o12227: r.next = 3'd7; 15'o12243: r.next = 3'd4; 15'o12254: r.next = 3'd7;
			15'o12324: r.next = 3'd4; 15'o12327: r.next = 3'd7; 15'o12425: r.next = 3'd5;
			15'o12426: r.next = 3'd7; 15'o12527: r.next = 3'd5;
			15'o20001: r.next = 3'd2; 15'o20002: r.next = 3'd2; 15'o20004: r.next = 3'd2;
			15'o20007: r.next = 3'd1; 15'o20012: r.next = 3'd2; 15'o20015: r.next = 3'd2;
			15'o20021: r.next = 3'd2; 15'o20022: r.next = 3'd2; 15'o20023: r.next = 3'd2;
			15'o20024: r.next = 3'd2; 15'o20025: r.next = 3'd0; 15'o20026: r.next = 3'd2;
			15'o20027: r.next = 3'd2; 15'o20032: r.next = 3'd6; 15'o20042: r.next = 3'd3;
			15'o20051: r.next = 3'd7; 15'o20052: r.next = 3'd2; 15'o20057: r.next = 3'd5;
			15'o20072: r.next = 3'd2; 15'o20102: r.next = 3'd2; 15'o20112: r.next = 3'd2;
			15'o20122: r.next = 3'd2; 15'o20142: r.next = 3'd2; 15'o20172: r.next = 3'd2;
			15'o20202: r.next = 3'd2; 15'o20203: r.next = 3'd2; 15'o20205: r.next = 3'd2;
			15'o20207: r.next = 3'd3; 15'o20212: r.next = 3'd2; 15'o20215: r.next = 3'd2;
			15'o20221: r.next = 3'd2; 15'o20222: r.next = 3'd2; 15'o20227: r.next = 3'd2;
			15'o20232: r.next = 3'd1; 15'o20242: r.next = 3'd2; 15'o20245: r.next = 3'd2;
			15'o20252: r.next = 3'd0; 15'o20255: r.next = 3'd2; 15'o20262: r.next = 3'd2;
			15'o20272: r.next = 3'd2; 15'o20312: r.next = 3'd2; 15'o20321: r.next = 3'd6;
			15'o20322: r.next = 3'd6; 15'o20342: r.next = 3'd2; 15'o20422: r.next = 3'd2;
			15'o20512: r.next = 3'd2; 15'o20521: r.next = 3'd2; 15'o20522: r.next = 3'd2;
			15'o20552: r.next = 3'd1; 15'o20572: r.next = 3'd5; 15'o20622: r.next = 3'd2;
			15'o20672: r.next = 3'd2; 15'o20712: r.next = 3'd2; 15'o20722: r.next = 3'd2;
			15'o20742: r.next = 3'd2; 15'o20772: r.next = 3'd2; 15'o21122: r.next = 3'd2;
			15'o21126: r.next = 3'd1; 15'o21222: r.next = 3'd2; 15'o21224: r.next = 3'd2;
			15'o21226: r.next = 3'd2; 15'o21227: r.next = 3'd2; 15'o21422: r.next = 3'd2;
			15'o21522: r.next = 3'd2; 15'o21622: r.next = 3'd2; 15'o21722: r.next = 3'd2;
			15'o22227: r.next = 3'd2; 15'o22244: r.next = 3'd2; 15'o22246: r.next = 3'd2;
			15'o22276: r.next = 3'd2; 15'o22277: r.next = 3'd2;
			15'o30001: r.next = 3'd3; 15'o30002: r.next = 3'd2; 15'o30004: r.next = 3'd1;
			15'o30007: r.next = 3'd6; 15'o30012: r.next = 3'd3; 15'o30042: r.next = 3'd1;
			15'o30062: r.next = 3'd2; 15'o30102: r.next = 3'd1; 15'o30122: r.next = 3'd0;
			15'o30251: r.next = 3'd1;
			15'o40112: r.next = 3'd0; 15'o40122: r.next = 3'd0; 15'o40125: r.next = 3'd0;
			15'o40212: r.next = 3'd0; 15'o40222: r.next = 3'd1; 15'o40232: r.next = 3'd6;
			15'o40252: r.next = 3'd0; 15'o40322: r.next = 3'd1;
			15'o50002: r.next = 3'd2; 15'o50021: r.next = 3'd5; 15'o50022: r.next = 3'd5;
			15'o50023: r.next = 3'd2; 15'o50027: r.next = 3'd2; 15'o50052: r.next = 3'd0;
			15'o50202: r.next = 3'd2; 15'o50212: r.next = 3'd2; 15'o50215: r.next = 3'd2;
			15'o50222: r.next = 3'd0; 15'o50224: r.next = 3'd4; 15'o50272: r.next = 3'd2;
			15'o51212: r.next = 3'd2; 15'o51222: r.next = 3'd0; 15'o51242: r.next = 3'd2;
			15'o51272: r.next = 3'd2;
			15'o60001: r.next = 3'd1; 15'o60002: r.next = 3'd1; 15'o60212: r.next = 3'd0;
			15'o61212: r.next = 3'd5; 15'o61213: r.next = 3'd1; 15'o61222: r.next = 3'd5;
			15'o70007: r.next = 3'd7; 15'o70112: r.next = 3'd0; 15'o70122: r.next = 3'd0;
			15'o70125: r.next = 3'd0; 15'o70212: r.next = 3'd0; 15'o70222: r.next = 3'd1;
			15'o70225: r.next = 3'd1; 15'o70232: r.next = 3'd1; 15'o70252: r.next = 3'd5;
			15'o70272: r.next = 3'd0;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/llr_stream_if.sv =====
// ----------------------------------------------------------------------------
// llr_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface llr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/llr_match.sv =====
// ----------------------------------------------------------------------------
// llr_match
// Rotation lookup: tries four rotations of the neighbourhood, first hit wins.
// ----------------------------------------------------------------------------
module llr_match (
	input  llr_pkg::cell_in_t  cell_in,
	output llr_pkg::cell_out_t res
);
	import llr_pkg::*;

	state_t    nb [4];
	rule_hit_t hit [4];

	assign nb[0] = cell_in.up_state;
	assign nb[1] = cell_in.right_state;
	assign nb[2] = cell_in.down_state;
	assign nb[3] = cell_in.left_state;

	// four independent table lookups
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			hit[r] = rule_lookup({cell_in.center_state, nb[r], nb[(r + 1) % 4],
				nb[(r + 2) % 4], nb[(r + 3) % 4]});
		end
	end

	// priority select, lowest rotation first
	always_comb begin
		if (hit[0].hit) begin
			res = '{next_state: hit[0].next, rule_matched: 1'b1};
		end else if (hit[1].hit) begin
			res = '{next_state: hit[1].next, rule_matched: 1'b1};
		end else if (hit[2].hit) begin
			res = '{next_state: hit[2].next, rule_matched: 1'b1};
		end else if (hit[3].hit) begin
			res = '{next_state: hit[3].next, rule_matched: 1'b1};
		end else begin
			res = '{next_state: cell_in.center_state, rule_matched: 1'b0};
		end
	end
endmodule

// ===== rtl/core/langton_loop_cell_rule_core.sv =====
// ----------------------------------------------------------------------------
// langton_loop_cell_rule_core
// Next-state rule of one cell of the eight-state self-replicating loop.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : sink of cell_in_t (centre and up/right/down/left states)
//   out_ch : source of cell_out_t (next_state, rule_matched)
//   A transaction on in_ch is registered, looked up through the fixed rule
//   table over four rotations, and the result registered for out_ch.
//   Throughput is one cell per cycle while out_ch ready stays high, set by
//   the single input register and result register, each refilled in the cycle it drains.
//   When the receiver stalls, the result register holds and the input
//   register takes one more transaction if it is empty; then in_ch ready drops.
//   Reset clears both valid flags; no results are pending afterwards.
// ----------------------------------------------------------------------------
module langton_loop_cell_rule_core (
	input logic clk,
	input logic arst_n,
	llr_stream_if.sink   in_ch,
	llr_stream_if.source out_ch
);
	import llr_pkg::*;

	cell_in_t  cell_s1;
	logic      vld_s1;
	cell_out_t res_s2;
	logic      vld_s2;
	cell_out_t res_c;
	logic      adv_s2;
	logic      adv_s1;

	assign adv_s2 = !vld_s2 || out_ch.ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			cell_s1 <= in_ch.data;
		end
	end

	llr_match u_match (
		.cell_in (cell_s1),
		.res     (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_ch.valid = vld_s2;
	assign out_ch.data  = res_s2;
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the loop automaton cell rule core: random and directed neighbourhoods
// are driven through a valid/ready channel, the next state is predicted from
// the rule list over four rotations and compared with each result transaction.
// ----------------------------------------------------------------------------
module tb;
	import llr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	llr_stream_if #(.payload_t(cell_in_t))  cell_in_ch ();
	llr_stream_if #(.payload_t(cell_out_t)) cell_out_ch ();

	langton_loop_cell_rule_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cell_in_ch.sink),
		.out_ch (cell_out_ch.source)
	);

	// rule list as decimal keys: centre then up/right/down/left digits
	int unsigned rule_keys[$] = '{
		0,1,2,3,5,6,7,11,12,13,21,22,23,26,27,32,52,62,72,102,112,202,203,205,212,
		222,232,522,1232,1242,1252,1262,1272,1275,1422,1432,1442,1472,1625,1722,
		1725,1752,1762,1772,2527,10001,10006,10007,10011,10012,10021,10024,10027,
		10051,10101,10111,10124,10127,10202,10212,10221,10224,10226,10227,10232,
		10242,10262,10264,10267,10271,10272,10542,11112,11122,11124,11125,11126,
		11127,11152,11212,11222,11224,11225,11227,11232,11242,11262,11272,11322,
		12224,12227,12243,12254,12324,12327,12425,12426,12527,20001,20002,20004,
		20007,20012,20015,20021,20022,20023,20024,20025,20026,20027,20032,20042,
		20051,20052,20057,20072,20102,20112,20122,20142,20172,20202,20203,20205,
		20207,20212,20215,20221,20222,20227,20232,20242,20245,20252,20255,20262,
		20272,20312,20321,20322,20342,20422,20512,20521,20522,20552,20572,20622,
		20672,20712,20722,20742,20772,21122,21126,21222,21224,21226,21227,21422,
		21522,21622,21722,22227,22244,22246,22276,22277,30001,30002,30004,30007,
		30012,30042,30062,30102,30122,30251,40112,40122,40125,40212,40222,40232,
		40252,40322,50002,50021,50022,50023,50027,50052,50202,50212,50215,50222,
		50224,50272,51212,51222,51242,51272,60001,60002,60212,61212,61213,61222,
		70007,70112,70122,70125,70212,70222,70225,70232,70252,70272};
	int unsigned rule_next[$] = '{
		0,2,0,0,0,3,1,2,2,2,2,0,0,2,2,0,5,2,2,2,0,0,0,0,5,
		0,2,2,1,1,5,1,1,1,1,1,1,1,1,1,
		5,1,1,1,1,1,1,7,1,1,1,4,7,
		1,1,1,4,7,6,1,1,4,3,7,7,
		4,6,4,7,0,7,7,1,1,4,1,1,
		7,2,1,1,4,1,7,1,4,1,7,1,
		4,7,4,7,4,7,5,7,5,2,2,2,
		1,2,2,2,2,2,2,0,2,2,6,3,
		7,2,5,2,2,2,2,2,2,2,2,2,
		3,2,2,2,2,2,1,2,2,0,2,2,
		2,2,6,6,2,2,2,2,2,1,5,2,
		2,2,2,2,2,2,1,2,2,2,2,2,
		2,2,2,2,2,2,2,2,3,2,1,6,
		3,1,2,1,0,1,0,0,0,0,1,6,
		0,1,2,5,5,2,2,0,2,2,2,0,
		4,2,2,0,2,2,1,1,0,5,1,5,
		7,0,0,0,0,1,1,1,5,0};

	cell_in_t  pending_cells[$];
	cell_out_t expected_states[$];
	bit        failed;
	bit        quiet;
	int        in_gap, out_gap;

	// next state over the four neighbour rotations, first hit wins
	function automatic cell_out_t next_cell_state(cell_in_t c);
		int unsigned nb[4];
		int unsigned key;
		cell_out_t   res;
		nb[0] = c.up_state; nb[1] = c.right_state;
		nb[2] = c.down_state; nb[3] = c.left_state;
		res.next_state   = c.center_state;
		res.rule_matched = 1'b0;
		for (int r = 0; r < 4; r++) begin
			key = c.center_state * 10000 + nb[r % 4] * 1000 + nb[(r + 1) % 4] * 100
				+ nb[(r + 2) % 4] * 10 + nb[(r + 3) % 4];
			for (int i = 0; i < rule_keys.size(); i++)
				if (rule_keys[i] == key) begin
					res.next_state   = state_t'(rule_next[i]);
					res.rule_matched = 1'b1;
					return res;
				end
		end
		return res;
	endfunction

	// build a cell from a decimal key, shifted by a rotation
	function automatic cell_in_t cell_from_key(int unsigned key, int rot);
		int unsigned d[4];
		cell_in_t    c;
		d[0] = (key / 1000) % 10; d[1] = (key / 100) % 10;
		d[2] = (key / 10) % 10;   d[3] = key % 10;
		c.center_state = state_t'(key / 10000);
		c.up_state     = state_t'(d[(4 - rot) % 4]);
		c.right_state  = state_t'(d[(5 - rot) % 4]);
		c.down_state   = state_t'(d[(6 - rot) % 4]);
		c.left_state   = state_t'(d[(7 - rot) % 4]);
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_in_ch.valid <= 1'b0;
			cell_in_ch.data  <= '0;
			in_gap           <= 0;
		end else begin
			// accepted transaction leaves the queue here, so the next one sits at the front
			if (cell_in_ch.valid && cell_in_ch.ready) begin
				expected_states.push_back(next_cell_state(cell_in_ch.data));
				void'(pending_cells.pop_front());
			end
			if (cell_in_ch.valid && !cell_in_ch.ready) begin
				// hold the offered transaction
			end else if (in_gap > 0) begin
				in_gap           <= in_gap - 1;
				cell_in_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				in_gap           <= $urandom_range(1, 13) - 1;
				cell_in_ch.valid <= 1'b0;
			end else if (pending_cells.size() > 0) begin
				cell_in_ch.valid <= 1'b1;
				cell_in_ch.data  <= pending_cells[0];
			end else begin
				cell_in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out_ch.ready <= 1'b0;
			out_gap           <= 0;
		end else begin
			if (cell_out_ch.valid && cell_out_ch.ready) begin
				if (expected_states.size() == 0) begin
					$display("%0t: unexpected result %p", $time, cell_out_ch.data);
					failed = 1'b1;
				end else begin
					if (cell_out_ch.data.next_state !== expected_states[0].next_state) begin
						$display("%0t: next_state expected %0d actual %0d", $time,
							expected_states[0].next_state, cell_out_ch.data.next_state);
						failed = 1'b1;
					end
					if (cell_out_ch.data.rule_matched !== expected_states[0].rule_matched) begin
						$display("%0t: rule_matched expected %0d actual %0d", $time,
							expected_states[0].rule_matched, cell_out_ch.data.rule_matched);
						failed = 1'b1;
					end
					void'(expected_states.pop_front());
				end
			end
			if (out_gap > 0) begin
				out_gap           <= out_gap - 1;
				cell_out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_gap           <= $urandom_range(1, 13) - 1;
				cell_out_ch.ready <= 1'b0;
			end else begin
				cell_out_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		cell_in_t c;
		int       pick;
		failed    = 1'b0;
		quiet     = 1'b0;
		arst_n    = 1'b0;
		// directed: extremes, no match, rotated matches, several rotations
		pending_cells.push_back('0);
		pending_cells.push_back('1);
		pending_cells.push_back(cell_from_key(70252, 0));
		pending_cells.push_back(cell_from_key(70252, 1));
		pending_cells.push_back(cell_from_key(70252, 2));
		pending_cells.push_back(cell_from_key(70252, 3));
		pending_cells.push_back(cell_from_key(10202, 1));
		pending_cells.push_back(cell_from_key(20032, 3));
		pending_cells.push_back(cell_from_key(1725, 2));
		pending_cells.push_back(cell_from_key(10007, 0));
		pending_cells.push_back(cell_from_key(1, 3));
		pending_cells.push_back(cell_from_key(77777, 0));
		pending_cells.push_back(cell_from_key(12345, 0));
		pending_cells.push_back(cell_from_key(40000, 0));
		pending_cells.push_back(cell_from_key(20222, 0));
		pending_cells.push_back(cell_from_key(61212, 1));
		repeat (2) @(posedge clk);
		arst_n = 1'b1;
		// random: mostly rule keys in random rotation, rest arbitrary
		for (int n = 0; n < 1800; n++) begin
			if (n == 1500) begin
				while (pending_cells.size() > 0) @(posedge clk);
				quiet = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick < 6)
				c = cell_from_key(rule_keys[$urandom_range(0, rule_keys.size() - 1)],
					$urandom_range(0, 3));
			else
				c = cell_in_t'($urandom);
			pending_cells.push_back(c);
		end
		while (pending_cells.size() > 0 || expected_states.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed && expected_states.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb: errors");
		$finish;
	end

endmodule
